### rtl/pwa_pkg.sv
`timescale 1ns / 1ps

package pwa_pkg;

  localparam int PWA_COORD_BITS       = 12;
  localparam int PWA_AFFINE_FRAC_BITS = 16;
  localparam int PWA_PERSP_FRAC_BITS  = 30;
  localparam int PWA_FIELD_W          = 12;

  // Width of the signed X, Y and W sums: 32 bit coefficient times a
  // non-negative coordinate, three terms.
  function automatic int pwa_num_width(input int coord_bits);
    return coord_bits + 35;
  endfunction

  typedef enum logic [2:0] {
    REG_COEF_XX      = 3'd0,
    REG_COEF_XY      = 3'd1,
    REG_COEF_XT      = 3'd2,
    REG_COEF_YX      = 3'd3,
    REG_COEF_YY      = 3'd4,
    REG_COEF_YT      = 3'd5,
    REG_PERSP_ROW    = 3'd6,
    REG_SOURCE_SIZE  = 3'd7
  } pwa_reg_e;

  typedef struct packed {
    logic [PWA_FIELD_W-1:0] dest_x;
    logic [PWA_FIELD_W-1:0] dest_y;
  } pwa_in_t;

  typedef struct packed {
    logic [PWA_FIELD_W-1:0] src_x;
    logic [PWA_FIELD_W-1:0] src_y;
    logic                   in_bounds;
  } pwa_out_t;

  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] xt;
    logic signed [31:0] yx;
    logic signed [31:0] yy;
    logic signed [31:0] yt;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } pwa_coef_t;

endpackage

### rtl/pwa_mac.sv
`timescale 1ns / 1ps

module pwa_mac #(
  parameter int COORD_BITS = pwa_pkg::PWA_COORD_BITS
) (
  input  logic                                              clk,
  input  logic                                              en,
  input  logic [COORD_BITS-1:0]                             x,
  input  logic [COORD_BITS-1:0]                             y,
  input  pwa_pkg::pwa_coef_t                                coef,
  output logic signed [pwa_pkg::pwa_num_width(COORD_BITS)-1:0] nx,
  output logic signed [pwa_pkg::pwa_num_width(COORD_BITS)-1:0] ny,
  output logic signed [pwa_pkg::pwa_num_width(COORD_BITS)-1:0] nw
);

  localparam int PW = COORD_BITS + 33;
  localparam int NW = pwa_pkg::pwa_num_width(COORD_BITS);
  localparam logic signed [NW-1:0] W_ONE = NW'(1) <<< pwa_pkg::PWA_PERSP_FRAC_BITS;

  logic signed [COORD_BITS:0] xs, ys;
  logic signed [PW-1:0] p_xx_r, p_xy_r, p_yx_r, p_yy_r, p_px_r, p_py_r;
  logic signed [NW-1:0] nx_r, ny_r, nw_r;

  assign xs = signed'({1'b0, x});
  assign ys = signed'({1'b0, y});

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx_r <= PW'(xs) * PW'(coef.xx);
      p_xy_r <= PW'(ys) * PW'(coef.xy);
      p_yx_r <= PW'(xs) * PW'(coef.yx);
      p_yy_r <= PW'(ys) * PW'(coef.yy);
      p_px_r <= PW'(xs) * PW'(coef.px);
      p_py_r <= PW'(ys) * PW'(coef.py);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= NW'(p_xx_r) + NW'(p_xy_r) + NW'(coef.xt);
      ny_r <= NW'(p_yx_r) + NW'(p_yy_r) + NW'(coef.yt);
      nw_r <= NW'(p_px_r) + NW'(p_py_r) + W_ONE;
    end
  end

  assign nx = nx_r;
  assign ny = ny_r;
  assign nw = nw_r;

endmodule

### rtl/pwa_div.sv
`timescale 1ns / 1ps

module pwa_div #(
  parameter int COORD_BITS       = pwa_pkg::PWA_COORD_BITS,
  parameter int AFFINE_FRAC_BITS = pwa_pkg::PWA_AFFINE_FRAC_BITS
) (
  input  logic                                              clk,
  input  logic                                              en,
  input  logic signed [pwa_pkg::pwa_num_width(COORD_BITS)-1:0] num,
  input  logic signed [pwa_pkg::pwa_num_width(COORD_BITS)-1:0] den,
  input  logic [15:0]                                       lim,
  output logic                                              ok,
  output logic [COORD_BITS-1:0]                             res
);

  localparam int NW = pwa_pkg::pwa_num_width(COORD_BITS);
  localparam int S  = pwa_pkg::PWA_PERSP_FRAC_BITS - AFFINE_FRAC_BITS;
  localparam int RW = NW + S + COORD_BITS + 1;
  localparam int QW = COORD_BITS + 1;
  localparam int NS = COORD_BITS + 2;

  // magnitude stage
  logic [NW-1:0] nabs, dabs;
  logic          neg_a_r, zero_a_r;
  logic [RW-1:0] n_a_r;
  logic [NW-1:0] d_a_r;
  logic [15:0]   lim_a_r;

  // quotient stages; index 0 is the overflow check stage
  logic [RW-1:0] rem_r  [0:NS-1];
  logic [QW-1:0] q_r    [0:NS-1];
  logic [NW-1:0] d_r    [0:NS-1];
  logic          neg_r  [0:NS-1];
  logic          zero_r [0:NS-1];
  logic          ovf_r  [0:NS-1];
  logic [15:0]   lim_r  [0:NS-1];

  logic                  rnd;
  logic [COORD_BITS+1:0] qr;
  logic                  ok_nxt;
  logic [COORD_BITS-1:0] res_nxt;
  logic                  ok_r;
  logic [COORD_BITS-1:0] res_r;

  assign nabs = num[NW-1] ? NW'(-num) : NW'(num);
  assign dabs = den[NW-1] ? NW'(-den) : NW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r  <= num[NW-1] ^ den[NW-1];
      zero_a_r <= (den == '0);
      n_a_r    <= RW'(nabs) << S;
      d_a_r    <= dabs;
      lim_a_r  <= lim;
    end
  end

  // quotient of 2^(COORD_BITS+1) or more is rejected up front
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= n_a_r;
      q_r[0]    <= '0;
      d_r[0]    <= d_a_r;
      neg_r[0]  <= neg_a_r;
      zero_r[0] <= zero_a_r;
      ovf_r[0]  <= n_a_r >= (RW'(d_a_r) << QW);
      lim_r[0]  <= lim_a_r;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_bit
    localparam int SH = QW - k;
    logic [RW-1:0] dsh;
    assign dsh = RW'(d_r[k-1]) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[k-1] >= dsh) begin
          rem_r[k] <= rem_r[k-1] - dsh;
          q_r[k]   <= q_r[k-1] | (QW'(1) << SH);
        end else begin
          rem_r[k] <= rem_r[k-1];
          q_r[k]   <= q_r[k-1];
        end
        d_r[k]    <= d_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        zero_r[k] <= zero_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        lim_r[k]  <= lim_r[k-1];
      end
    end
  end

  // round half away from zero on the magnitude, then range checks
  always_comb begin
    rnd     = (rem_r[NS-1] << 1) >= RW'(d_r[NS-1]);
    qr      = (COORD_BITS+2)'(q_r[NS-1]) + (COORD_BITS+2)'(rnd);
    ok_nxt  = 1'b0;
    res_nxt = '0;
    if (zero_r[NS-1] || ovf_r[NS-1]) begin
      ok_nxt = 1'b0;
    end else if (qr == '0) begin
      ok_nxt = (lim_r[NS-1] != '0);
    end else begin
      ok_nxt = !neg_r[NS-1] && (32'(qr) < 32'(lim_r[NS-1]))
               && (qr[COORD_BITS+1:COORD_BITS] == '0);
      if (ok_nxt) begin
        res_nxt = qr[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r  <= ok_nxt;
      res_r <= res_nxt;
    end
  end

  assign ok  = ok_r;
  assign res = res_r;

endmodule

### rtl/perspective_warp_address.sv
`timescale 1ns / 1ps

// Perspective warp address generator. Each item is a destination pixel; the
// block maps it through the 3x3 projective matrix held in the configuration
// registers, divides by the perspective term and returns the nearest source
// pixel with an in-bounds flag (coordinates are zero when out of bounds).
// One item is taken every clock unless out_stall holds the pipeline. The divider
// resolves one quotient bit per pipeline stage, after two multiply/accumulate
// stages, a magnitude stage and an overflow check, and before a rounding stage.
// out_stall holds the whole pipeline. Write the registers only while no item is
// in flight.
module perspective_warp_address #(
  parameter int COORD_BITS       = pwa_pkg::PWA_COORD_BITS,
  parameter int AFFINE_FRAC_BITS = pwa_pkg::PWA_AFFINE_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pwa_pkg::pwa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pwa_pkg::pwa_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam int NW    = pwa_pkg::pwa_num_width(COORD_BITS);
  localparam int DEPTH = COORD_BITS + 6;

  logic [31:0] coef_xx_r, coef_xy_r, coef_xt_r;
  logic [31:0] coef_yx_r, coef_yy_r, coef_yt_r;
  logic [63:0] persp_r;
  logic [31:0] source_size_r;

  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             en;

  pwa_pkg::pwa_coef_t    coef;
  logic signed [NW-1:0]  nx, ny, nw;
  logic                  ok_x, ok_y, hit;
  logic [COORD_BITS-1:0] sx, sy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r     <= 32'(1) << AFFINE_FRAC_BITS;
      coef_xy_r     <= '0;
      coef_xt_r     <= '0;
      coef_yx_r     <= '0;
      coef_yy_r     <= 32'(1) << AFFINE_FRAC_BITS;
      coef_yt_r     <= '0;
      persp_r       <= '0;
      source_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (pwa_pkg::pwa_reg_e'(cfg_index))
        pwa_pkg::REG_COEF_XX:     coef_xx_r     <= cfg_data[31:0];
        pwa_pkg::REG_COEF_XY:     coef_xy_r     <= cfg_data[31:0];
        pwa_pkg::REG_COEF_XT:     coef_xt_r     <= cfg_data[31:0];
        pwa_pkg::REG_COEF_YX:     coef_yx_r     <= cfg_data[31:0];
        pwa_pkg::REG_COEF_YY:     coef_yy_r     <= cfg_data[31:0];
        pwa_pkg::REG_COEF_YT:     coef_yt_r     <= cfg_data[31:0];
        pwa_pkg::REG_PERSP_ROW:   persp_r       <= cfg_data;
        pwa_pkg::REG_SOURCE_SIZE: source_size_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign coef.xx = signed'(coef_xx_r);
  assign coef.xy = signed'(coef_xy_r);
  assign coef.xt = signed'(coef_xt_r);
  assign coef.yx = signed'(coef_yx_r);
  assign coef.yy = signed'(coef_yy_r);
  assign coef.yt = signed'(coef_yt_r);
  assign coef.px = signed'(persp_r[31:0]);
  assign coef.py = signed'(persp_r[63:32]);

  // all stages move together; only a held result blocks the pipe
  assign en       = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall = !en;

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  pwa_mac #(
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk  (clk),
    .en   (en),
    .x    (COORD_BITS'(in_data.dest_x)),
    .y    (COORD_BITS'(in_data.dest_y)),
    .coef (coef),
    .nx   (nx),
    .ny   (ny),
    .nw   (nw)
  );

  pwa_div #(
    .COORD_BITS       (COORD_BITS),
    .AFFINE_FRAC_BITS (AFFINE_FRAC_BITS)
  ) u_div_x (
    .clk (clk),
    .en  (en),
    .num (nx),
    .den (nw),
    .lim (source_size_r[15:0]),
    .ok  (ok_x),
    .res (sx)
  );

  pwa_div #(
    .COORD_BITS       (COORD_BITS),
    .AFFINE_FRAC_BITS (AFFINE_FRAC_BITS)
  ) u_div_y (
    .clk (clk),
    .en  (en),
    .num (ny),
    .den (nw),
    .lim (source_size_r[31:16]),
    .ok  (ok_y),
    .res (sy)
  );

  assign hit                = ok_x && ok_y;
  assign out_valid          = vld_r[DEPTH-1];
  assign out_data.in_bounds = hit;
  assign out_data.src_x     = hit ? pwa_pkg::PWA_FIELD_W'(sx) : '0;
  assign out_data.src_y     = hit ? pwa_pkg::PWA_FIELD_W'(sy) : '0;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_bounds |-> out_data.src_x == '0 && out_data.src_y == '0)
    else $error("out-of-bounds item carries a non-zero coordinate");

  a_hit_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_bounds |->
      (16'(out_data.src_x) < source_size_r[15:0])
      && (16'(out_data.src_y) < source_size_r[31:16]))
    else $error("in-bounds item lies outside the source image");

  a_empty_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_bounds |->
      source_size_r[15:0] != '0 && source_size_r[31:16] != '0)
    else $error("in-bounds item with an empty source image");

endmodule

### sim/perspective_warp_address_tb.sv
`timescale 1ns / 1ps

module perspective_warp_address_tb;

  localparam int CB        = pwa_pkg::PWA_COORD_BITS;
  localparam int FRAC_GAP  = pwa_pkg::PWA_PERSP_FRAC_BITS - pwa_pkg::PWA_AFFINE_FRAC_BITS;
  localparam int LATENCY   = CB + 6;
  localparam int MAX_CYCLES = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pwa_pkg::pwa_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pwa_pkg::pwa_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  perspective_warp_address i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the matrix and image size
  pwa_pkg::pwa_coef_t mat;
  logic [15:0] src_w, src_h;

  pwa_pkg::pwa_out_t pixel_q[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_inside = 0;
  int          cycles = 0;
  bit          sink_idle_en = 1'b1;
  bit          src_idle_en = 1'b1;
  int          hold_cycles = 0;

  function automatic bit warp_axis(input logic signed [63:0] num,
                                   input logic signed [63:0] den,
                                   input logic [15:0] lim,
                                   output logic [CB-1:0] res);
    logic [63:0] n, d, q, r, cap;
    bit neg;
    res = '0;
    if (den == 0) return 1'b0;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    cap = 64'd1 << (CB + 1);
    q = n / d;
    r = n % d;
    if (q >= cap) return 1'b0;
    for (int i = 0; i < FRAC_GAP; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
      if (q >= cap) return 1'b0;
    end
    if (r >= d - r) q = q + 1;
    if (q == 0) return lim != 0;
    if (neg || q >= {48'd0, lim} || (q >> CB) != 0) return 1'b0;
    res = q[CB-1:0];
    return 1'b1;
  endfunction

  function automatic pwa_pkg::pwa_out_t warp_pixel(input pwa_pkg::pwa_in_t px_in);
    logic signed [63:0] x, y, nx, ny, w;
    logic [CB-1:0] sx, sy;
    bit okx, oky;
    pwa_pkg::pwa_out_t r;
    x = {52'd0, px_in.dest_x[CB-1:0]};
    y = {52'd0, px_in.dest_y[CB-1:0]};
    nx = 64'(mat.xx) * x + 64'(mat.xy) * y + 64'(mat.xt);
    ny = 64'(mat.yx) * x + 64'(mat.yy) * y + 64'(mat.yt);
    w  = 64'(mat.px) * x + 64'(mat.py) * y
         + (64'sd1 <<< pwa_pkg::PWA_PERSP_FRAC_BITS);
    okx = warp_axis(nx, w, src_w, sx);
    oky = warp_axis(ny, w, src_h, sy);
    r = '0;
    if (okx && oky) begin
      r.src_x = sx;
      r.src_y = sy;
      r.in_bounds = 1'b1;
    end
    return r;
  endfunction

  // cfg_valid stays high between writes; load_matrix drops it at the end
  task automatic write_reg(input pwa_pkg::pwa_reg_e idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pwa_pkg::REG_COEF_XX:     mat.xx = val[31:0];
      pwa_pkg::REG_COEF_XY:     mat.xy = val[31:0];
      pwa_pkg::REG_COEF_XT:     mat.xt = val[31:0];
      pwa_pkg::REG_COEF_YX:     mat.yx = val[31:0];
      pwa_pkg::REG_COEF_YY:     mat.yy = val[31:0];
      pwa_pkg::REG_COEF_YT:     mat.yt = val[31:0];
      pwa_pkg::REG_PERSP_ROW:   {mat.py, mat.px} = val;
      pwa_pkg::REG_SOURCE_SIZE: {src_h, src_w} = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_matrix(input logic [31:0] xx, xy, xt, yx, yy, yt,
                             input logic [31:0] px, py, input logic [15:0] w, h);
    drain();
    write_reg(pwa_pkg::REG_COEF_XX, {32'd0, xx});
    write_reg(pwa_pkg::REG_COEF_XY, {32'd0, xy});
    write_reg(pwa_pkg::REG_COEF_XT, {32'd0, xt});
    write_reg(pwa_pkg::REG_COEF_YX, {32'd0, yx});
    write_reg(pwa_pkg::REG_COEF_YY, {32'd0, yy});
    write_reg(pwa_pkg::REG_COEF_YT, {32'd0, yt});
    write_reg(pwa_pkg::REG_PERSP_ROW, {py, px});
    write_reg(pwa_pkg::REG_SOURCE_SIZE, {32'd0, h, w});
    cfg_valid <= 1'b0;
  endtask

  // valid held until accepted; payload steady while stalled
  task automatic send_pixel(input logic [11:0] dx, input logic [11:0] dy);
    pwa_pkg::pwa_in_t it;
    it.dest_x = dx;
    it.dest_y = dy;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pixel_q = {pixel_q, warp_pixel(it)};
    n_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_data);
        errors++;
      end else begin
        pwa_pkg::pwa_out_t e;
        e = pixel_q.pop_front();
        if (e.src_x !== out_data.src_x)
          $display("%0t: src_x exp %0d got %0d", $time, e.src_x, out_data.src_x);
        if (e.src_y !== out_data.src_y)
          $display("%0t: src_y exp %0d got %0d", $time, e.src_y, out_data.src_y);
        if (e.in_bounds !== out_data.in_bounds)
          $display("%0t: in_bounds exp %0b got %0b", $time, e.in_bounds,
                   out_data.in_bounds);
        if (e !== out_data) errors++;
        n_checked++;
        if (e.in_bounds) n_inside++;
      end
    end
  end

  // receiver stall: random bursts, or a long hold-off on request
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (burst - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_identity_edges;
    load_matrix(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 16'd4096, 16'd4096);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 0);
    send_pixel(0, 12'hFFF);
    send_pixel(12'hAAA, 12'h555);
  endtask

  task automatic test_special_cases;
    // zero source size: all out of bounds
    load_matrix(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 16'd0, 16'd0);
    send_pixel(0, 0);
    send_pixel(5, 7);
    // negative shift: -0.3 rounds to zero, -0.5 and below go negative
    load_matrix(32'h0001_0000, 0, 32'hFFFF_B334, 0, 32'h0001_0000, 32'hFFFF_8000,
                0, 0, 16'd100, 16'd100);
    send_pixel(0, 0);
    send_pixel(1, 1);
    // half a pixel rounds away from zero
    load_matrix(32'h0001_0000, 0, 32'h0000_8000, 0, 32'h0001_0000, 32'h0000_8000,
                0, 0, 16'd64, 16'd64);
    send_pixel(3, 63);
    // zero denominator at x = 1, negative denominator beyond
    load_matrix(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 32'hC000_0000, 0,
                16'hFFFF, 16'hFFFF);
    send_pixel(1, 0);
    send_pixel(2, 3);
    send_pixel(0, 9);
    // overflow and unrepresentable coordinate
    load_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                16'hFFFF, 16'hFFFF);
    send_pixel(12'hFFF, 0);
    send_pixel(0, 12'hFFF);
    load_matrix(32'h0002_0000, 0, 0, 0, 32'h0002_0000, 0, 0, 0, 16'hFFFF, 16'hFFFF);
    send_pixel(12'hFFF, 1);
    send_pixel(2047, 2047);
    // projective: tiny perspective terms
    load_matrix(32'h0001_2000, 32'hFFFF_F000, 32'h0010_0000, 32'h0000_0800,
                32'h0000_E000, 32'hFFF8_0000, 32'h0000_4000, 32'hFFFF_E000,
                16'd2000, 16'd1500);
    send_pixel(100, 200);
    send_pixel(12'hFFF, 12'hFFF);
  endtask

  task automatic random_matrix;
    logic [31:0] c[8];
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 4))
        0: c[i] = $urandom;
        1: c[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: c[i] = 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      endcase
    end
    for (int i = 6; i < 8; i++) begin
      case ($urandom_range(0, 3))
        0: c[i] = $urandom;
        1: c[i] = 0;
        default: c[i] = 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      endcase
    end
    load_matrix(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4200)),
                $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4200)));
  endtask

  task automatic test_random;
    for (int s = 0; s < 15; s++) begin
      random_matrix();
      repeat (55) send_pixel(12'($urandom), 12'($urandom));
    end
  endtask

  task automatic test_backpressure;
    load_matrix(32'h0000_C000, 32'h0000_4000, 32'h0004_0000, 32'hFFFF_C000,
                32'h0001_0000, 32'h0020_0000, 32'h0000_1000, 0, 16'd3000, 16'd3000);
    @(posedge clk);
    hold_cycles = 200;
    repeat (60) send_pixel(12'($urandom), 12'($urandom));
  endtask

  task automatic test_full_rate;
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    load_matrix(32'h0001_0000, 0, 32'hFFF0_0000, 0, 32'h0001_0000, 32'h0008_0000,
                0, 0, 16'd4095, 16'd4095);
    repeat (50) send_pixel(12'($urandom), 12'($urandom));
  endtask

  initial begin
    mat = '0;
    mat.xx = 32'h0001_0000;
    mat.yy = 32'h0001_0000;
    src_w = '0;
    src_h = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_edges();
    test_special_cases();
    test_backpressure();
    test_random();
    test_full_rate();
    drain();
    $display("%0d items sent, %0d results checked, %0d in bounds", n_sent, n_checked,
             n_inside);
    $display("covered edges, zero size, rounding, zero/negative W, overflow, stalls");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
